/* design/ddsfm_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the dual sound FIFO mixer.
// Depends on nothing; used by every module of the block.
package ddsfm_pkg;

    // Input request kinds carried in s_tuser[1:0]
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_TIMER = 2'd1,
        OP_TICK  = 2'd2,
        OP_RESET = 2'd3
    } op_t;

    // Configuration register indexes
    localparam logic [2:0] CFG_MASTER_EN = 3'd0;
    localparam logic [2:0] CFG_FULL_VOL  = 3'd1;
    localparam logic [2:0] CFG_ROUTE_A   = 3'd2;
    localparam logic [2:0] CFG_ROUTE_B   = 3'd3;
    localparam logic [2:0] CFG_TSEL_A    = 3'd4;
    localparam logic [2:0] CFG_TSEL_B    = 3'd5;
    localparam logic [2:0] CFG_BIAS      = 3'd6;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 10;
    localparam int SAMPLE_W    = 8;
    localparam int WORD_W      = 32;
    localparam int PUSH_BYTES  = 4;
    localparam int MIX_W       = 10;
    localparam int IN_USER_W   = 4;
    localparam int OUT_DATA_W  = 24;
    localparam logic [MIX_W-1:0] MIX_MAX = 10'h3FF;

    // Per-channel FIFO command for one request
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } chan_cmd_t;

    // Mixer settings
    typedef struct packed {
        logic             enable;
        logic [1:0]       full_vol;
        logic [1:0]       route_a;
        logic [1:0]       route_b;
        logic [MIX_W-1:0] bias;
    } mix_cfg_t;

    // Pick one byte of a packed word, byte 0 lowest
    function automatic logic [SAMPLE_W-1:0] byte_of(input logic [WORD_W-1:0] word,
                                                    input logic [1:0] sel);
        logic [SAMPLE_W-1:0] b;
        unique case (sel)
            2'd0:    b = word[7:0];
            2'd1:    b = word[15:8];
            2'd2:    b = word[23:16];
            default: b = word[31:24];
        endcase
        return b;
    endfunction

endpackage

/* design/ddsfm_cell.sv */
`timescale 1ns / 1ps
// One sample cell of the shifting FIFO chain.
// Depends on ddsfm_pkg for the sample width.
module ddsfm_cell
(
    input  logic                           clk,
    input  logic                           load,
    input  logic [ddsfm_pkg::SAMPLE_W-1:0] load_byte,
    input  logic                           shift,
    input  logic [ddsfm_pkg::SAMPLE_W-1:0] next_byte,
    output logic [ddsfm_pkg::SAMPLE_W-1:0] byte_q
);

    logic [ddsfm_pkg::SAMPLE_W-1:0] byte_reg;
    logic [ddsfm_pkg::SAMPLE_W-1:0] byte_next;

    // Take a pushed byte, or advance the neighbor's byte on a pop
    always_comb
    begin
        byte_next = byte_reg;
        if (load)
        begin
            byte_next = load_byte;
        end
        else if (shift)
        begin
            byte_next = next_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign byte_q = byte_reg;

endmodule

/* design/ddsfm_chain.sv */
`timescale 1ns / 1ps
// One channel: a row of sample cells with the head in cell 0, fill count
// and current sample. Depends on ddsfm_pkg and ddsfm_cell.
module ddsfm_chain #(
    parameter int DEPTH     = 32,
    parameter int REP_LEVEL = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  ddsfm_pkg::chan_cmd_t           cmd,
    input  logic [ddsfm_pkg::WORD_W-1:0]   data_word,
    output logic [ddsfm_pkg::SAMPLE_W-1:0] current,
    output logic                           low_after_pop
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;
    logic [CNT_W-1:0]              count_popped;
    logic [CNT_W:0]                count_sum;
    logic [ddsfm_pkg::SAMPLE_W-1:0] current_reg;
    logic [ddsfm_pkg::SAMPLE_W-1:0] current_next;
    logic                          not_empty;
    logic                          shift;
    logic [ddsfm_pkg::SAMPLE_W-1:0] cell_q [DEPTH];

    assign not_empty    = (count_reg != '0);
    assign shift        = cmd.pop && not_empty;
    assign count_popped = count_reg - CNT_W'(not_empty);
    assign count_sum    = (CNT_W + 1)'(count_reg) + (CNT_W + 1)'(ddsfm_pkg::PUSH_BYTES);

    // Build the cell row; each cell loads its byte when it lies in the push window
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [CNT_W-1:0]               offset;
        logic                           load;
        logic [ddsfm_pkg::SAMPLE_W-1:0] neighbor;

        assign offset = CNT_W'(i) - count_reg;
        assign load   = cmd.push && (CNT_W'(i) >= count_reg)
                        && (offset < CNT_W'(ddsfm_pkg::PUSH_BYTES));

        if (i == DEPTH - 1)
        begin : g_last
            assign neighbor = cell_q[i];
        end
        else
        begin : g_mid
            assign neighbor = cell_q[i+1];
        end

        ddsfm_cell u_cell (
            .clk       (clk),
            .load      (load),
            .load_byte (ddsfm_pkg::byte_of(data_word, offset[1:0])),
            .shift     (shift),
            .next_byte (neighbor),
            .byte_q    (cell_q[i])
        );
    end

    // Update fill count and current sample
    always_comb
    begin
        count_next   = count_reg;
        current_next = current_reg;
        priority if (cmd.clear)
        begin
            count_next   = '0;
            current_next = '0;
        end
        else if (cmd.push)
        begin
            if (count_sum > (CNT_W + 1)'(DEPTH))
            begin
                count_next = CNT_W'(DEPTH);
            end
            else
            begin
                count_next = count_sum[CNT_W-1:0];
            end
        end
        else if (cmd.pop)
        begin
            count_next = count_popped;
            if (not_empty)
            begin
                current_next = cell_q[0];
            end
        end
        else
        begin
            // Hold count and current sample
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            current_reg <= '0;
        end
        else
        begin
            count_reg   <= count_next;
            current_reg <= current_next;
        end
    end

    assign current       = current_reg;
    assign low_after_pop = (32'(count_popped) < 32'(REP_LEVEL));

endmodule

/* design/ddsfm_mix.sv */
`timescale 1ns / 1ps
// Mixer: scale, route, bias and clip the two current samples.
// Depends on ddsfm_pkg.
module ddsfm_mix
(
    input  logic [ddsfm_pkg::SAMPLE_W-1:0] cur_a,
    input  logic [ddsfm_pkg::SAMPLE_W-1:0] cur_b,
    input  ddsfm_pkg::mix_cfg_t            cfg,
    output logic [ddsfm_pkg::MIX_W-1:0]    left,
    output logic [ddsfm_pkg::MIX_W-1:0]    right
);

    logic signed [8:0]  a_s;
    logic signed [8:0]  b_s;
    logic signed [11:0] sum_l;
    logic signed [11:0] sum_r;

    // Halve toward zero unless full volume
    function automatic logic signed [8:0] scale(input logic [7:0] s, input logic full);
        logic signed [8:0] ext;
        ext = $signed({s[7], s});
        if (full)
        begin
            return ext;
        end
        return (ext + $signed({8'b0, s[7]})) >>> 1;
    endfunction

    // Clip a signed sum to the output range
    function automatic logic [9:0] clip(input logic signed [11:0] v);
        if (v < 0)
        begin
            return '0;
        end
        if (v > $signed({2'b00, ddsfm_pkg::MIX_MAX}))
        begin
            return ddsfm_pkg::MIX_MAX;
        end
        return v[9:0];
    endfunction

    assign a_s = scale(cur_a, cfg.full_vol[0]);
    assign b_s = scale(cur_b, cfg.full_vol[1]);

    // Route and add bias
    always_comb
    begin
        sum_l = $signed({2'b00, cfg.bias});
        sum_r = $signed({2'b00, cfg.bias});
        if (cfg.route_a[1])
        begin
            sum_l = sum_l + 12'(a_s);
        end
        if (cfg.route_a[0])
        begin
            sum_r = sum_r + 12'(a_s);
        end
        if (cfg.route_b[1])
        begin
            sum_l = sum_l + 12'(b_s);
        end
        if (cfg.route_b[0])
        begin
            sum_r = sum_r + 12'(b_s);
        end
    end

    assign left  = cfg.enable ? clip(sum_l) : '0;
    assign right = cfg.enable ? clip(sum_r) : '0;

endmodule

/* design/dual_dma_sound_fifo_mixer.sv */
`timescale 1ns / 1ps
// Dual sound FIFO mixer top level. A request's result goes to the output register, or to
// the skid register while the output stalls; one request per cycle is sustained while the skid
// is empty, since each request updates the cell rows and counters as it is accepted.
// A two-entry output stage (register plus skid) keeps s_tready high while one result waits.
// Reset (rst_n, async, active low) empties both FIFOs, zeroes current samples and
// all configuration registers; FIFO cell contents are left as they are.
module dual_dma_sound_fifo_mixer #(
    parameter int FIFO_DEPTH      = 32,
    parameter int REPLENISH_LEVEL = 16
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    // Input requests
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [ddsfm_pkg::WORD_W-1:0]     s_tdata,   // [31:0] data_word
    input  logic [ddsfm_pkg::IN_USER_W-1:0]  s_tuser,   // [1:0] opcode, [2] channel, [3] timer_id
    // Results
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ddsfm_pkg::OUT_DATA_W-1:0] m_tdata,   // [0] replenish_a, [1] replenish_b,
                                                        // [11:2] left_out, [21:12] right_out,
                                                        // [23:22] zero
    // Configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ddsfm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ddsfm_pkg::CFG_DATA_W-1:0] cfg_data
);

    ddsfm_pkg::op_t       op;
    logic                 channel;
    logic                 timer_id;
    logic                 accept;
    ddsfm_pkg::chan_cmd_t cmd_a;
    ddsfm_pkg::chan_cmd_t cmd_b;
    ddsfm_pkg::mix_cfg_t  mix_cfg;
    logic                 pop_a;
    logic                 pop_b;

    logic [ddsfm_pkg::SAMPLE_W-1:0] cur_a;
    logic [ddsfm_pkg::SAMPLE_W-1:0] cur_b;
    logic                           low_a;
    logic                           low_b;
    logic [ddsfm_pkg::MIX_W-1:0]    mix_l;
    logic [ddsfm_pkg::MIX_W-1:0]    mix_r;
    logic [ddsfm_pkg::OUT_DATA_W-1:0] result;

    logic                 master_en_reg;
    logic [1:0]           full_vol_reg;
    logic [1:0]           route_a_reg;
    logic [1:0]           route_b_reg;
    logic                 tsel_a_reg;
    logic                 tsel_b_reg;
    logic [ddsfm_pkg::MIX_W-1:0] bias_reg;

    logic                             out_valid_reg;
    logic [ddsfm_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic                             skid_valid_reg;
    logic [ddsfm_pkg::OUT_DATA_W-1:0] skid_data_reg;

    // Decode the request
    assign op       = ddsfm_pkg::op_t'(s_tuser[1:0]);
    assign channel  = s_tuser[2];
    assign timer_id = s_tuser[3];
    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign pop_a    = accept && (op == ddsfm_pkg::OP_TIMER) && (tsel_a_reg == timer_id);
    assign pop_b    = accept && (op == ddsfm_pkg::OP_TIMER) && (tsel_b_reg == timer_id);

    assign cmd_a.push  = accept && (op == ddsfm_pkg::OP_WRITE) && !channel;
    assign cmd_a.pop   = pop_a;
    assign cmd_a.clear = accept && (op == ddsfm_pkg::OP_RESET) && !channel;
    assign cmd_b.push  = accept && (op == ddsfm_pkg::OP_WRITE) && channel;
    assign cmd_b.pop   = pop_b;
    assign cmd_b.clear = accept && (op == ddsfm_pkg::OP_RESET) && channel;

    ddsfm_chain #(.DEPTH(FIFO_DEPTH), .REP_LEVEL(REPLENISH_LEVEL)) u_chain_a (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd_a),
        .data_word     (s_tdata),
        .current       (cur_a),
        .low_after_pop (low_a)
    );

    ddsfm_chain #(.DEPTH(FIFO_DEPTH), .REP_LEVEL(REPLENISH_LEVEL)) u_chain_b (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd_b),
        .data_word     (s_tdata),
        .current       (cur_b),
        .low_after_pop (low_b)
    );

    assign mix_cfg.enable   = master_en_reg;
    assign mix_cfg.full_vol = full_vol_reg;
    assign mix_cfg.route_a  = route_a_reg;
    assign mix_cfg.route_b  = route_b_reg;
    assign mix_cfg.bias     = bias_reg;

    ddsfm_mix u_mix (
        .cur_a (cur_a),
        .cur_b (cur_b),
        .cfg   (mix_cfg),
        .left  (mix_l),
        .right (mix_r)
    );

    // Assemble the result of this request
    always_comb
    begin
        result = '0;
        result[0] = pop_a && low_a;
        result[1] = pop_b && low_b;
        if (op == ddsfm_pkg::OP_TICK)
        begin
            result[11:2]  = mix_l;
            result[21:12] = mix_r;
        end
    end

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            master_en_reg <= 1'b0;
            full_vol_reg  <= '0;
            route_a_reg   <= '0;
            route_b_reg   <= '0;
            tsel_a_reg    <= 1'b0;
            tsel_b_reg    <= 1'b0;
            bias_reg      <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ddsfm_pkg::CFG_MASTER_EN: master_en_reg <= cfg_data[0];
                ddsfm_pkg::CFG_FULL_VOL:  full_vol_reg  <= cfg_data[1:0];
                ddsfm_pkg::CFG_ROUTE_A:   route_a_reg   <= cfg_data[1:0];
                ddsfm_pkg::CFG_ROUTE_B:   route_b_reg   <= cfg_data[1:0];
                ddsfm_pkg::CFG_TSEL_A:    tsel_a_reg    <= cfg_data[0];
                ddsfm_pkg::CFG_TSEL_B:    tsel_b_reg    <= cfg_data[0];
                ddsfm_pkg::CFG_BIAS:      bias_reg      <= cfg_data[9:0];
                default:
                begin
                end
            endcase
        end
    end

    // Output register with skid stage; drain the skid first
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Hold payload alongside the valid flags
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_tready)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : result;
        end
        else if (accept)
        begin
            skid_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

/* design/ddsfm_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the dual sound FIFO mixer, bound to the top level.
// Depends on ddsfm_pkg and dual_dma_sound_fifo_mixer.
module ddsfm_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [ddsfm_pkg::OUT_DATA_W-1:0] m_tdata
);

    // Hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Show an accepted request's result in the next cycle when the output side is free
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (!m_tvalid || m_tready) |=> m_tvalid)
        else $error("accepted request produced no result");

    // Drop no mix into a replenish result and vice versa
    a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1:0] != 2'b00) |-> (m_tdata[21:2] == 20'd0))
        else $error("replenish and mix in one result");

    // Keep padding bits at zero
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[23:22] == 2'b00))
        else $error("padding bits set");

endmodule

bind dual_dma_sound_fifo_mixer ddsfm_checker u_ddsfm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* bench/dual_dma_sound_fifo_mixer_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for the dual sound FIFO mixer: directed table, then random phases
// under changing mixer settings and idle patterns. Depends on ddsfm_pkg and the block.
module dual_dma_sound_fifo_mixer_tb;

    localparam int FIFO_DEPTH      = 32;
    localparam int REPLENISH_LEVEL = 16;
    localparam int PHASES          = 8;
    localparam int PHASE_ITEMS     = 166;
    localparam int CYCLE_LIMIT     = 400000;
    // Index past the last register; the block must ignore it
    localparam logic [ddsfm_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    // One result of the block
    typedef struct packed {
        logic [ddsfm_pkg::MIX_W-1:0] right;
        logic [ddsfm_pkg::MIX_W-1:0] left;
        logic                        rep_b;
        logic                        rep_a;
    } mix_res_t;

    // One row of the directed table; fixed rows carry their own expectation
    typedef struct {
        ddsfm_pkg::op_t op;
        bit             ch;
        bit [31:0]      word;
        bit             tid;
        bit             fixed;
        mix_res_t       want;
    } dir_row_t;

    logic                             clk;
    logic                             rst_n;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [ddsfm_pkg::WORD_W-1:0]     s_tdata;    // [31:0] data_word
    logic [ddsfm_pkg::IN_USER_W-1:0]  s_tuser;    // [1:0] opcode, [2] channel, [3] timer_id
    logic                             m_tvalid;
    logic                             m_tready;
    logic [ddsfm_pkg::OUT_DATA_W-1:0] m_tdata;    // [0] rep_a, [1] rep_b, [11:2] left,
                                                  // [21:12] right
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [ddsfm_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [ddsfm_pkg::CFG_DATA_W-1:0] cfg_data;

    // Predicted FIFO contents and mixer settings
    logic [ddsfm_pkg::SAMPLE_W-1:0] cells [2][FIFO_DEPTH];
    int                             fill_cnt [2];
    int                             head_ptr [2];
    logic [ddsfm_pkg::SAMPLE_W-1:0] cur_smp [2];
    logic                           mix_en;
    logic [1:0]                     full_vol;
    logic [1:0]                     route [2];
    logic                           tsel [2];
    logic [ddsfm_pkg::MIX_W-1:0]    bias;

    mix_res_t mix_q [$];
    dir_row_t dir_rows [$];
    int       err_cnt;
    int       cycle_cnt;
    int       send_idle_pct;
    int       recv_stall_pct;

    dual_dma_sound_fifo_mixer #(
        .FIFO_DEPTH      (FIFO_DEPTH),
        .REPLENISH_LEVEL (REPLENISH_LEVEL)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Pop one channel into its current sample; flag a refill when running low
    function automatic logic pop_chan(input int ch);
        if (fill_cnt[ch] > 0)
        begin
            cur_smp[ch]  = cells[ch][head_ptr[ch]];
            head_ptr[ch] = (head_ptr[ch] + 1) % FIFO_DEPTH;
            fill_cnt[ch] = fill_cnt[ch] - 1;
        end
        return (fill_cnt[ch] < REPLENISH_LEVEL);
    endfunction

    // Signed sample, halved toward zero unless at full volume
    function automatic int scaled_smp(input int ch, input logic full);
        int s;
        s = $signed(cur_smp[ch]);
        return full ? s : s / 2;
    endfunction

    function automatic logic [ddsfm_pkg::MIX_W-1:0] clip_mix(input int v);
        if (v < 0)
            return '0;
        if (v > int'(ddsfm_pkg::MIX_MAX))
            return ddsfm_pkg::MIX_MAX;
        return v[ddsfm_pkg::MIX_W-1:0];
    endfunction

    // Advance the predicted state by one request and return its result
    function automatic mix_res_t predict_mix(input ddsfm_pkg::op_t op, input bit ch,
                                             input bit [31:0] word, input bit tid);
        mix_res_t r;
        int a;
        int b;
        int l;
        int rt;
        r = '0;
        unique case (op)
            ddsfm_pkg::OP_WRITE:
            begin
                for (int k = 0; k < ddsfm_pkg::PUSH_BYTES; k++)
                begin
                    if (fill_cnt[ch] < FIFO_DEPTH)
                    begin
                        cells[ch][(head_ptr[ch] + fill_cnt[ch]) % FIFO_DEPTH] = word[8*k +: 8];
                        fill_cnt[ch] = fill_cnt[ch] + 1;
                    end
                end
            end
            ddsfm_pkg::OP_TIMER:
            begin
                if (tsel[0] == tid)
                    r.rep_a = pop_chan(0);
                if (tsel[1] == tid)
                    r.rep_b = pop_chan(1);
            end
            ddsfm_pkg::OP_TICK:
            begin
                if (mix_en)
                begin
                    a  = scaled_smp(0, full_vol[0]);
                    b  = scaled_smp(1, full_vol[1]);
                    l  = int'(bias);
                    rt = int'(bias);
                    if (route[0][1]) l  += a;
                    if (route[0][0]) rt += a;
                    if (route[1][1]) l  += b;
                    if (route[1][0]) rt += b;
                    r.left  = clip_mix(l);
                    r.right = clip_mix(rt);
                end
            end
            default:
            begin
                fill_cnt[ch] = 0;
                head_ptr[ch] = 0;
                cur_smp[ch]  = '0;
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle_cnt);
        err_cnt++;
    endtask

    // Offer one request, hold it until accepted, then record its expectation
    task automatic send_req(input ddsfm_pkg::op_t op, input bit ch, input bit [31:0] word,
                            input bit tid, input bit fixed, input mix_res_t want);
        mix_res_t pred;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= {tid, ch, op};
        do @(posedge clk); while (!s_tready);
        pred = predict_mix(op, ch, word, tid);
        mix_q.push_back(fixed ? want : pred);
    endtask

    // Drop the request line and wait until every result is back
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (mix_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [ddsfm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ddsfm_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            ddsfm_pkg::CFG_MASTER_EN: mix_en   = val[0];
            ddsfm_pkg::CFG_FULL_VOL:  full_vol = val[1:0];
            ddsfm_pkg::CFG_ROUTE_A:   route[0] = val[1:0];
            ddsfm_pkg::CFG_ROUTE_B:   route[1] = val[1:0];
            ddsfm_pkg::CFG_TSEL_A:    tsel[0]  = val[0];
            ddsfm_pkg::CFG_TSEL_B:    tsel[1]  = val[0];
            ddsfm_pkg::CFG_BIAS:      bias     = val;
            default:                  ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Program all mixer settings for one random phase
    task automatic set_mixer(input int p);
        logic [ddsfm_pkg::CFG_DATA_W-1:0] v [7];
        if (p == 0)
        begin
            v = '{10'd1, 10'd3, 10'd3, 10'd3, 10'd1, 10'd1, 10'h3FF};
        end
        else if (p == 1)
        begin
            v = '{10'd1, 10'd0, 10'd3, 10'd3, 10'd0, 10'd0, 10'd0};
        end
        else if (p == 2)
        begin
            v = '{10'd0, 10'd2, 10'd2, 10'd1, 10'd0, 10'd1, 10'd512};
        end
        else
        begin
            v[0] = 10'($urandom_range(0, 3) != 0);
            v[1] = 10'($urandom_range(0, 3));
            v[2] = 10'($urandom_range(0, 3));
            v[3] = 10'($urandom_range(0, 3));
            v[4] = 10'($urandom_range(0, 1));
            v[5] = 10'($urandom_range(0, 1));
            v[6] = ($urandom_range(0, 1) != 0) ? 10'($urandom_range(0, 1023))
                                               : 10'($urandom_range(0, 40));
        end
        write_cfg(ddsfm_pkg::CFG_MASTER_EN, v[0]);
        write_cfg(ddsfm_pkg::CFG_FULL_VOL,  v[1]);
        write_cfg(ddsfm_pkg::CFG_ROUTE_A,   v[2]);
        write_cfg(ddsfm_pkg::CFG_ROUTE_B,   v[3]);
        write_cfg(ddsfm_pkg::CFG_TSEL_A,    v[4]);
        write_cfg(ddsfm_pkg::CFG_TSEL_B,    v[5]);
        write_cfg(ddsfm_pkg::CFG_BIAS,      v[6]);
        // The spare index must leave every setting alone
        if (p == 3)
            write_cfg(CFG_SPARE, 10'h3FF);
    endtask

    task automatic add_row(input ddsfm_pkg::op_t op, input bit ch, input bit [31:0] word,
                           input bit tid, input bit fixed, input mix_res_t want);
        dir_row_t row;
        row.op    = op;
        row.ch    = ch;
        row.word  = word;
        row.tid   = tid;
        row.fixed = fixed;
        row.want  = want;
        dir_rows.push_back(row);
    endtask

    // Randomize the receiver side each cycle
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Compare each result against the oldest expectation
    always @(posedge clk)
    begin
        mix_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (mix_q.size() == 0)
            begin
                report_mismatch("unexpected result", int'(m_tdata), 0);
            end
            else
            begin
                want = mix_q.pop_front();
                if (m_tdata[0] !== want.rep_a)
                    report_mismatch("replenish_a", int'(m_tdata[0]), int'(want.rep_a));
                if (m_tdata[1] !== want.rep_b)
                    report_mismatch("replenish_b", int'(m_tdata[1]), int'(want.rep_b));
                if (m_tdata[11:2] !== want.left)
                    report_mismatch("left_out", int'(m_tdata[11:2]), int'(want.left));
                if (m_tdata[21:12] !== want.right)
                    report_mismatch("right_out", int'(m_tdata[21:12]), int'(want.right));
            end
        end
    end

    // Hard stop for a hung run
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        mix_res_t       zero_res;
        mix_res_t       both_low;
        ddsfm_pkg::op_t op;
        int             pick;
        int             wr_pct;

        clk            = 1'b0;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        m_tready       = 1'b1;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        err_cnt        = 0;
        cycle_cnt      = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fill_cnt       = '{0, 0};
        head_ptr       = '{0, 0};
        cur_smp        = '{8'h00, 8'h00};
        mix_en         = 1'b0;
        full_vol       = '0;
        route          = '{2'b00, 2'b00};
        tsel           = '{1'b0, 1'b0};
        bias           = '0;
        zero_res       = '0;
        both_low       = '0;
        both_low.rep_a = 1'b1;
        both_low.rep_b = 1'b1;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table, run with the reset settings
        add_row(ddsfm_pkg::OP_TICK,  1'b0, 32'h0000_0000, 1'b0, 1'b1, zero_res);
        // both empty, same timer
        add_row(ddsfm_pkg::OP_TIMER, 1'b0, 32'h0000_0000, 1'b0, 1'b1, both_low);
        // no channel on timer 1
        add_row(ddsfm_pkg::OP_TIMER, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1, zero_res);
        add_row(ddsfm_pkg::OP_WRITE, 1'b0, 32'h807F_FF00, 1'b0, 1'b1, zero_res);
        add_row(ddsfm_pkg::OP_WRITE, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b1, zero_res);
        add_row(ddsfm_pkg::OP_WRITE, 1'b0, 32'h0000_0000, 1'b0, 1'b1, zero_res);
        add_row(ddsfm_pkg::OP_WRITE, 1'b0, 32'h8080_8080, 1'b0, 1'b1, zero_res);
        add_row(ddsfm_pkg::OP_WRITE, 1'b0, 32'h7F7F_7F7F, 1'b0, 1'b1, zero_res);
        add_row(ddsfm_pkg::OP_WRITE, 1'b0, 32'h0102_0304, 1'b0, 1'b1, zero_res);
        add_row(ddsfm_pkg::OP_WRITE, 1'b0, 32'hFEFD_FCFB, 1'b0, 1'b1, zero_res);
        // A now full
        add_row(ddsfm_pkg::OP_WRITE, 1'b0, 32'h55AA_33CC, 1'b0, 1'b1, zero_res);
        // all dropped
        add_row(ddsfm_pkg::OP_WRITE, 1'b0, 32'h1234_5678, 1'b0, 1'b1, zero_res);
        add_row(ddsfm_pkg::OP_TIMER, 1'b0, 32'h0000_0000, 1'b0, 1'b0, zero_res);
        // one kept, three dropped
        add_row(ddsfm_pkg::OP_WRITE, 1'b0, 32'hAABB_CCDD, 1'b1, 1'b1, zero_res);
        add_row(ddsfm_pkg::OP_WRITE, 1'b1, 32'h7F80_FF01, 1'b0, 1'b1, zero_res);
        // both popped together
        add_row(ddsfm_pkg::OP_TIMER, 1'b0, 32'h0000_0000, 1'b0, 1'b0, zero_res);
        // mixing disabled
        add_row(ddsfm_pkg::OP_TICK,  1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1, zero_res);
        add_row(ddsfm_pkg::OP_RESET, 1'b0, 32'h0000_0000, 1'b0, 1'b1, zero_res);
        add_row(ddsfm_pkg::OP_RESET, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1, zero_res);
        add_row(ddsfm_pkg::OP_TIMER, 1'b0, 32'h0000_0000, 1'b0, 1'b1, both_low);
        add_row(ddsfm_pkg::OP_WRITE, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1, zero_res);
        add_row(ddsfm_pkg::OP_TIMER, 1'b1, 32'h0000_0000, 1'b0, 1'b0, zero_res);
        foreach (dir_rows[i])
            send_req(dir_rows[i].op, dir_rows[i].ch, dir_rows[i].word,
                     dir_rows[i].tid, dir_rows[i].fixed, dir_rows[i].want);
        drain_results();

        // Random phases: new settings and a new idle pattern each time
        for (int p = 0; p < PHASES; p++)
        begin
            set_mixer(p);
            unique case (p % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 82;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 82;
                end
                default:
                begin
                    send_idle_pct  = 7;
                    recv_stall_pct = 7;
                end
            endcase
            // Even phases fill the FIFOs, odd phases run them dry
            wr_pct = (p % 2 == 0) ? 50 : 25;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // Hold off once until every result is back
                if (p == 2 && i == 80)
                    drain_results();
                pick = $urandom_range(0, 99);
                if (pick < wr_pct)
                    op = ddsfm_pkg::OP_WRITE;
                else if (pick < wr_pct + 35)
                    op = ddsfm_pkg::OP_TIMER;
                else if (pick < 95)
                    op = ddsfm_pkg::OP_TICK;
                else
                    op = ddsfm_pkg::OP_RESET;
                send_req(op, 1'($urandom_range(0, 1)), $urandom,
                         1'($urandom_range(0, 1)), 1'b0, zero_res);
            end
            drain_results();
        end

        repeat (5) @(posedge clk);
        if (err_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
